FILE: rtl/core/depth_pixel_backprojection_macros.svh
// Assertion macros used by the checker of this block.
`ifndef DEPTH_PIXEL_BACKPROJECTION_MACROS_SVH
`define DEPTH_PIXEL_BACKPROJECTION_MACROS_SVH

// Same-cycle implication, ignored while reset is held.
`define DPB_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, ignored while reset is held.
`define DPB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also holds across reset.
`define DPB_ASSERT_ALWAYS_NEXT(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/dpb_pkg.sv
package dpb_pkg;

    localparam int unsigned COL_W   = 11;
    localparam int unsigned DEPTH_W = 16;
    localparam int unsigned CTR_W   = 16;
    localparam int unsigned RECIP_W = 24;
    localparam int unsigned CH_W    = 8;
    localparam int unsigned POS_W   = 32;

    localparam int unsigned S_DATA_W = 64;   // 62 bits of fields, padded to bytes
    localparam int unsigned M_DATA_W = 120;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 24;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_DEPTH   = 3'd0,
        CFG_INV_SCALE   = 3'd1,
        CFG_CENTER_X    = 3'd2,
        CFG_CENTER_Y    = 3'd3,
        CFG_INV_FOCAL_X = 3'd4,
        CFG_INV_FOCAL_Y = 3'd5
    } t_cfg_reg;

    localparam logic [DEPTH_W-1:0] RST_MAX_DEPTH   = 16'd5000;
    localparam logic [RECIP_W-1:0] RST_INV_SCALE   = 24'd16777;
    localparam logic [CTR_W-1:0]   RST_CENTER_X    = 16'd10584;
    localparam logic [CTR_W-1:0]   RST_CENTER_Y    = 16'd7345;
    localparam logic [RECIP_W-1:0] RST_INV_FOCAL_X = 24'd27235;
    localparam logic [RECIP_W-1:0] RST_INV_FOCAL_Y = 24'd26995;

endpackage

FILE: rtl/core/depth_pixel_backprojection.sv
// Pinhole back-projection of a depth pixel to a colored 3-D point.
// Datapath: an accepted pixel passes stage 1 to stage 5 and then the output register
// before o_m_tvalid rises; an output stall holds it where it is.
// Throughput: one pixel per cycle; each of the six register stages takes a new item
// every cycle while the output is not stalled.
// Pixels with zero or out-of-range depth are taken and give no output transfer.
// Reset (i_rst_n low, synchronous) empties the pipeline and loads register defaults.
module depth_pixel_backprojection (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // config write channel
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [dpb_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [dpb_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // pixel in
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    // column[10:0], row[21:11], depth[37:22], blue[45:38], green[53:46],
    // red[61:54], zero pad[63:62]
    input  logic [dpb_pkg::S_DATA_W-1:0]     i_s_tdata,
    // point out
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // x_pos[31:0], y_pos[63:32], z_pos[95:64], out_blue[103:96],
    // out_green[111:104], out_red[119:112]
    output logic [dpb_pkg::M_DATA_W-1:0]     o_m_tdata
);
    import dpb_pkg::*;

    // Final step: q = s >> 5, sticky remainder, floor for negative, saturate.
    function automatic logic [POS_W-1:0] sat_project(input logic [47:0] s,
                                                     input logic        rem_lo,
                                                     input logic        neg);
        logic [42:0]      q;
        logic             rem;
        logic             big;
        logic [POS_W-1:0] res;
        q   = s[47:5];
        rem = (|s[4:0]) | rem_lo;
        if (!neg) begin
            res = (|q[42:31]) ? 32'h7FFF_FFFF : q[31:0];
        end else begin
            big = (|q[42:32]) | (q[31] & ((|q[30:0]) | rem));
            res = big ? 32'h8000_0000 : (~q[31:0] + {31'b0, ~rem});
        end
        return res;
    endfunction

    // ---------------- configuration registers ----------------
    logic [DEPTH_W-1:0] r_max_depth;
    logic [RECIP_W-1:0] r_inv_scale;
    logic [CTR_W-1:0]   r_center_x;
    logic [CTR_W-1:0]   r_center_y;
    logic [RECIP_W-1:0] r_inv_focal_x;
    logic [RECIP_W-1:0] r_inv_focal_y;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_depth   <= RST_MAX_DEPTH;
            r_inv_scale   <= RST_INV_SCALE;
            r_center_x    <= RST_CENTER_X;
            r_center_y    <= RST_CENTER_Y;
            r_inv_focal_x <= RST_INV_FOCAL_X;
            r_inv_focal_y <= RST_INV_FOCAL_Y;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_reg'(i_cfg_index))
                CFG_MAX_DEPTH:   r_max_depth   <= i_cfg_data[DEPTH_W-1:0];
                CFG_INV_SCALE:   r_inv_scale   <= i_cfg_data;
                CFG_CENTER_X:    r_center_x    <= i_cfg_data[CTR_W-1:0];
                CFG_CENTER_Y:    r_center_y    <= i_cfg_data[CTR_W-1:0];
                CFG_INV_FOCAL_X: r_inv_focal_x <= i_cfg_data;
                CFG_INV_FOCAL_Y: r_inv_focal_y <= i_cfg_data;
                default: ;   // indexes past the register list are dropped
            endcase
        end
    end

    // ---------------- input unpack ----------------
    logic [COL_W-1:0]   in_col;
    logic [COL_W-1:0]   in_row;
    logic [DEPTH_W-1:0] in_depth;
    logic [3*CH_W-1:0]  in_bgr;
    logic [CTR_W-1:0]   in_px32;
    logic [CTR_W-1:0]   in_py32;
    logic               in_keep;

    assign in_col   = i_s_tdata[10:0];
    assign in_row   = i_s_tdata[21:11];
    assign in_depth = i_s_tdata[37:22];
    assign in_bgr   = i_s_tdata[61:38];
    assign in_px32  = {in_col, 5'b0};
    assign in_py32  = {in_row, 5'b0};
    // zero depth and depth at/above the limit are both "no measurement"
    assign in_keep  = (in_depth != '0) && (in_depth < r_max_depth);

    // ---------------- stage valids and per-stage advance ----------------
    // Each stage loads when it is empty or its successor moves, so bubbles
    // collapse and a stall at the output backs up one stage at a time.
    logic r_v1, r_v2, r_v3, r_v4, r_v5, r_vo;
    logic en1, en2, en3, en4, en5, en_o;

    assign en_o = !r_vo || i_m_tready;
    assign en5  = !r_v5 || en_o;
    assign en4  = !r_v4 || en5;
    assign en3  = !r_v3 || en4;
    assign en2  = !r_v2 || en3;
    assign en1  = !r_v1 || en2;

    assign o_s_tready = en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            // a dropped pixel is taken but enters as a bubble
            if (en1)  r_v1 <= i_s_tvalid && in_keep;
            if (en2)  r_v2 <= r_v1;
            if (en3)  r_v3 <= r_v2;
            if (en4)  r_v4 <= r_v3;
            if (en5)  r_v5 <= r_v4;
            if (en_o) r_vo <= r_v5;
        end
    end

    // ---------------- stage 1: offsets from principal point ----------------
    logic [DEPTH_W-1:0] r_s1_depth;
    logic [CTR_W-1:0]   r_s1_mag_x, r_s1_mag_y;
    logic               r_s1_neg_x, r_s1_neg_y;
    logic [3*CH_W-1:0]  r_s1_bgr;

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_s1_depth <= in_depth;
            r_s1_neg_x <= in_px32 < r_center_x;
            r_s1_mag_x <= (in_px32 < r_center_x) ? (r_center_x - in_px32)
                                                 : (in_px32 - r_center_x);
            r_s1_neg_y <= in_py32 < r_center_y;
            r_s1_mag_y <= (in_py32 < r_center_y) ? (r_center_y - in_py32)
                                                 : (in_py32 - r_center_y);
            r_s1_bgr   <= in_bgr;
        end
    end

    // ---------------- stage 2: z = depth * inv_scale >> 8 ----------------
    logic [39:0]        s2_zprod;
    logic [POS_W-1:0]   r_s2_z;
    logic [CTR_W-1:0]   r_s2_mag_x, r_s2_mag_y;
    logic               r_s2_neg_x, r_s2_neg_y;
    logic [3*CH_W-1:0]  r_s2_bgr;

    assign s2_zprod = {24'b0, r_s1_depth} * {16'b0, r_inv_scale};

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r_s2_z     <= s2_zprod[39:8];
            r_s2_mag_x <= r_s1_mag_x;
            r_s2_mag_y <= r_s1_mag_y;
            r_s2_neg_x <= r_s1_neg_x;
            r_s2_neg_y <= r_s1_neg_y;
            r_s2_bgr   <= r_s1_bgr;
        end
    end

    // ---------------- stage 3: p = |offset| * z ----------------
    logic [47:0]        r_s3_p_x, r_s3_p_y;
    logic [POS_W-1:0]   r_s3_z;
    logic               r_s3_neg_x, r_s3_neg_y;
    logic [3*CH_W-1:0]  r_s3_bgr;

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r_s3_p_x   <= {32'b0, r_s2_mag_x} * {16'b0, r_s2_z};
            r_s3_p_y   <= {32'b0, r_s2_mag_y} * {16'b0, r_s2_z};
            r_s3_z     <= r_s2_z;
            r_s3_neg_x <= r_s2_neg_x;
            r_s3_neg_y <= r_s2_neg_y;
            r_s3_bgr   <= r_s2_bgr;
        end
    end

    // ---------------- stage 4: split p into 24-bit halves times 1/f ----------------
    logic [47:0]        r_s4_lo_x, r_s4_hi_x, r_s4_lo_y, r_s4_hi_y;
    logic [POS_W-1:0]   r_s4_z;
    logic               r_s4_neg_x, r_s4_neg_y;
    logic [3*CH_W-1:0]  r_s4_bgr;

    always_ff @(posedge i_clk) begin
        if (en4) begin
            r_s4_lo_x  <= {24'b0, r_s3_p_x[23:0]}  * {24'b0, r_inv_focal_x};
            r_s4_hi_x  <= {24'b0, r_s3_p_x[47:24]} * {24'b0, r_inv_focal_x};
            r_s4_lo_y  <= {24'b0, r_s3_p_y[23:0]}  * {24'b0, r_inv_focal_y};
            r_s4_hi_y  <= {24'b0, r_s3_p_y[47:24]} * {24'b0, r_inv_focal_y};
            r_s4_z     <= r_s3_z;
            r_s4_neg_x <= r_s3_neg_x;
            r_s4_neg_y <= r_s3_neg_y;
            r_s4_bgr   <= r_s3_bgr;
        end
    end

    // ---------------- stage 5: recombine, keep sticky low bits ----------------
    // full product = s * 2^24 + lo[23:0]; s fits 48 bits
    logic [47:0]        r_s5_s_x, r_s5_s_y;
    logic               r_s5_rem_x, r_s5_rem_y;
    logic [POS_W-1:0]   r_s5_z;
    logic               r_s5_neg_x, r_s5_neg_y;
    logic [3*CH_W-1:0]  r_s5_bgr;

    always_ff @(posedge i_clk) begin
        if (en5) begin
            r_s5_s_x   <= r_s4_hi_x + {24'b0, r_s4_lo_x[47:24]};
            r_s5_s_y   <= r_s4_hi_y + {24'b0, r_s4_lo_y[47:24]};
            r_s5_rem_x <= |r_s4_lo_x[23:0];
            r_s5_rem_y <= |r_s4_lo_y[23:0];
            r_s5_z     <= r_s4_z;
            r_s5_neg_x <= r_s4_neg_x;
            r_s5_neg_y <= r_s4_neg_y;
            r_s5_bgr   <= r_s4_bgr;
        end
    end

    // ---------------- output register: shift by 29 total, saturate ----------------
    logic [M_DATA_W-1:0] r_out;

    always_ff @(posedge i_clk) begin
        if (en_o) begin
            r_out <= {r_s5_bgr, r_s5_z,
                      sat_project(r_s5_s_y, r_s5_rem_y, r_s5_neg_y),
                      sat_project(r_s5_s_x, r_s5_rem_x, r_s5_neg_x)};
        end
    end

    assign o_m_tvalid = r_vo;
    assign o_m_tdata  = r_out;

endmodule

FILE: rtl/core/dpb_checker.sv
`include "depth_pixel_backprojection_macros.svh"

module dpb_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_m_tvalid,
    input logic                          i_m_tready,
    input logic [dpb_pkg::M_DATA_W-1:0]  o_m_tdata
);
    import dpb_pkg::*;

    logic             m_stall;
    logic [POS_W-1:0] z_pos;
    logic             z_zero;
    logic             xy_zero;

    assign m_stall = o_m_tvalid && !i_m_tready;
    assign z_pos   = o_m_tdata[95:64];
    assign z_zero  = (z_pos == '0);
    assign xy_zero = (o_m_tdata[63:0] == '0);

    `DPB_ASSERT_ALWAYS_NEXT(a_rst_empty, i_clk, !i_rst_n, !o_m_tvalid, "output valid after reset")
    `DPB_ASSERT_NEXT(a_hold_valid, i_clk, i_rst_n, m_stall, o_m_tvalid, "valid dropped")
    `DPB_ASSERT_NEXT(a_hold_data, i_clk, i_rst_n, m_stall, $stable(o_m_tdata), "data moved")
    // zero depth in metres leaves nothing to project
    `DPB_ASSERT_NOW(a_zero_z, i_clk, i_rst_n, o_m_tvalid && z_zero, xy_zero, "x/y nonzero at z zero")

endmodule

bind depth_pixel_backprojection dpb_checker u_dpb_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

FILE: tb/sv/depth_pixel_backprojection_tb.sv
module depth_pixel_backprojection_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dpb_pkg::*;

    // Give a pixel with no point time to fall out of the pipe before any register
    // write or the end of the run.
    localparam int SETTLE_CYCLES = 12;
    localparam int RANDOM_PHASES = 14;
    localparam int PHASE_PIXELS  = 125;
    localparam int RUN_LIMIT_NS  = 10_000_000;

    // Register indexes past the last register: writes to them must be dropped.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    localparam logic signed [79:0] POS_LIMIT = 80'sd2147483647;
    localparam logic signed [79:0] NEG_LIMIT = -80'sd2147483648;

    typedef struct packed {
        logic [COL_W-1:0]   column;
        logic [COL_W-1:0]   row;
        logic [DEPTH_W-1:0] depth;
        logic [CH_W-1:0]    blue;
        logic [CH_W-1:0]    green;
        logic [CH_W-1:0]    red;
    } t_pixel;

    typedef struct packed {
        logic [POS_W-1:0] x_pos;
        logic [POS_W-1:0] y_pos;
        logic [POS_W-1:0] z_pos;
        logic [CH_W-1:0]  blue;
        logic [CH_W-1:0]  green;
        logic [CH_W-1:0]  red;
    } t_point;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                  i_s_tvalid  = 1'b0;
    logic                  o_s_tready;
    logic [S_DATA_W-1:0]   i_s_tdata   = '0;
    logic                  o_m_tvalid;
    logic                  i_m_tready  = 1'b0;
    logic [M_DATA_W-1:0]   o_m_tdata;

    // Shadow copy of the block's registers, updated on each config transfer.
    logic [DEPTH_W-1:0] max_depth_r   = RST_MAX_DEPTH;
    logic [RECIP_W-1:0] inv_scale_r   = RST_INV_SCALE;
    logic [CTR_W-1:0]   center_x_r    = RST_CENTER_X;
    logic [CTR_W-1:0]   center_y_r    = RST_CENTER_Y;
    logic [RECIP_W-1:0] inv_focal_x_r = RST_INV_FOCAL_X;
    logic [RECIP_W-1:0] inv_focal_y_r = RST_INV_FOCAL_Y;

    t_point pending_points[$];   // points owed by the block, oldest first
    int     mismatch_count = 0;

    // Traffic shaping knobs set by the tests.
    bit tx_steady   = 1'b0;   // sender offers back to back
    bit rx_steady   = 1'b0;   // receiver always ready
    int rx_hold_req = 0;      // one-shot receiver hold-off, in cycles

    depth_pixel_backprojection DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Point prediction
    // ------------------------------------------------------------------

    // floor((pix*32 - center) * z * recip / 2^29), clamped to signed 32 bits.
    // 80 bits hold the full product (18 + 33 + 25 bits) with room to spare.
    function automatic logic [POS_W-1:0] project_axis(input logic [COL_W-1:0] pix,
                                                      input logic [CTR_W-1:0] center,
                                                      input logic [POS_W-1:0] z,
                                                      input logic [RECIP_W-1:0] recip);
        logic signed [17:0] pix_offset;
        logic signed [79:0] scaled;
        pix_offset = $signed({2'b00, pix, 5'b00000}) - $signed({2'b00, center});
        scaled = (pix_offset * $signed({1'b0, z}) * $signed({1'b0, recip})) >>> 29;
        if (scaled > POS_LIMIT)
            return {1'b0, {(POS_W-1){1'b1}}};
        if (scaled < NEG_LIMIT)
            return {1'b1, {(POS_W-1){1'b0}}};
        return scaled[POS_W-1:0];
    endfunction

    // Returns 1 with the point when the pixel's depth is usable, else 0.
    function automatic bit backproject_pixel(input t_pixel px, output t_point pt);
        logic [39:0] depth_m;
        pt = '0;
        if (px.depth == '0 || px.depth >= max_depth_r)
            return 1'b0;
        depth_m  = 40'(px.depth) * 40'(inv_scale_r);
        pt.z_pos = depth_m[39:8];
        pt.x_pos = project_axis(px.column, center_x_r, pt.z_pos, inv_focal_x_r);
        pt.y_pos = project_axis(px.row, center_y_r, pt.z_pos, inv_focal_y_r);
        pt.blue  = px.blue;
        pt.green = px.green;
        pt.red   = px.red;
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic t_pixel make_pixel(input int col, input int row, input int depth,
                                          input int blue, input int green, input int red);
        t_pixel px;
        px.column = COL_W'(col);
        px.row    = COL_W'(row);
        px.depth  = DEPTH_W'(depth);
        px.blue   = CH_W'(blue);
        px.green  = CH_W'(green);
        px.red    = CH_W'(red);
        return px;
    endfunction

    // Most pixels carry a usable depth; the rest are zero or out of range.
    function automatic t_pixel random_pixel();
        t_pixel px;
        int     roll;
        px.column = COL_W'($urandom_range(0, (1 << COL_W) - 1));
        px.row    = COL_W'($urandom_range(0, (1 << COL_W) - 1));
        px.blue   = CH_W'($urandom_range(0, 255));
        px.green  = CH_W'($urandom_range(0, 255));
        px.red    = CH_W'($urandom_range(0, 255));
        roll = $urandom_range(0, 99);
        if (roll < 6)
            px.depth = '0;
        else if (roll < 14 || max_depth_r < 2)
            px.depth = DEPTH_W'($urandom_range(max_depth_r, (1 << DEPTH_W) - 1));
        else
            px.depth = DEPTH_W'($urandom_range(1, max_depth_r - 1));
        return px;
    endfunction

    // Reciprocal registers: extremes, realistic values, or anything.
    function automatic logic [CFG_DATA_W-1:0] pick_recip();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 8)
            return '1;
        if (roll < 14)
            return '0;
        if (roll < 55)
            return CFG_DATA_W'($urandom_range(8000, 70000));
        return CFG_DATA_W'($urandom());
    endfunction

    // Principal point; junk in the upper byte must be masked by the block.
    function automatic logic [CFG_DATA_W-1:0] pick_center();
        int roll;
        logic [CTR_W-1:0] center;
        roll = $urandom_range(0, 99);
        if (roll < 10)
            center = '0;
        else if (roll < 20)
            center = '1;
        else
            center = CTR_W'($urandom_range(0, 65535));
        return {8'($urandom_range(0, 255)), center};
    endfunction

    // One config transfer; the shadow registers follow it.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (index)
            CFG_MAX_DEPTH:   max_depth_r   = value[DEPTH_W-1:0];
            CFG_INV_SCALE:   inv_scale_r   = value[RECIP_W-1:0];
            CFG_CENTER_X:    center_x_r    = value[CTR_W-1:0];
            CFG_CENTER_Y:    center_y_r    = value[CTR_W-1:0];
            CFG_INV_FOCAL_X: inv_focal_x_r = value[RECIP_W-1:0];
            CFG_INV_FOCAL_Y: inv_focal_y_r = value[RECIP_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Offer one pixel, book its point at the transfer, then maybe idle.
    // A zero gap keeps tvalid high into the next pixel.
    task automatic send_pixel(input t_pixel px);
        t_point pt;
        int     gap;
        @(negedge i_clk);
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= S_DATA_W'({px.red, px.green, px.blue, px.depth, px.row, px.column});
        do @(posedge i_clk); while (!o_s_tready);
        if (backproject_pixel(px, pt))
            pending_points.insert(pending_points.size(), pt);
        gap = tx_steady ? 0 : pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            i_s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    // Stop offering, wait for every owed point, then let the pipe empty.
    task automatic drain_points();
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (pending_points.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reset_values();
        write_reg(CFG_MAX_DEPTH,   CFG_DATA_W'(RST_MAX_DEPTH));
        write_reg(CFG_INV_SCALE,   CFG_DATA_W'(RST_INV_SCALE));
        write_reg(CFG_CENTER_X,    CFG_DATA_W'(RST_CENTER_X));
        write_reg(CFG_CENTER_Y,    CFG_DATA_W'(RST_CENTER_Y));
        write_reg(CFG_INV_FOCAL_X, CFG_DATA_W'(RST_INV_FOCAL_X));
        write_reg(CFG_INV_FOCAL_Y, CFG_DATA_W'(RST_INV_FOCAL_Y));
    endtask

    task automatic randomize_registers();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 10)
            write_reg(CFG_MAX_DEPTH, 24'h00FFFF);
        else if (roll < 15)
            write_reg(CFG_MAX_DEPTH, CFG_DATA_W'($urandom_range(0, 16)));
        else
            write_reg(CFG_MAX_DEPTH, {8'($urandom_range(0, 255)),
                                      16'($urandom_range(1000, 65535))});
        write_reg(CFG_INV_SCALE,   pick_recip());
        write_reg(CFG_CENTER_X,    pick_center());
        write_reg(CFG_CENTER_Y,    pick_center());
        write_reg(CFG_INV_FOCAL_X, pick_recip());
        write_reg(CFG_INV_FOCAL_Y, pick_recip());
        if ($urandom_range(0, 3) == 0)
            write_reg($urandom_range(0, 1) ? CFG_SPARE_HI : CFG_SPARE_LO,
                      CFG_DATA_W'($urandom()));
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset register values: depth limits, field extremes, colors.
    task automatic test_reset_defaults();
        send_pixel(make_pixel(0, 0, 0, 8'hFF, 8'hFF, 8'hFF));          // no depth
        send_pixel(make_pixel(0, 0, 1, 0, 0, 0));                      // smallest depth
        send_pixel(make_pixel(2047, 2047, RST_MAX_DEPTH - 1, 8'hFF, 8'hFF, 8'hFF));
        send_pixel(make_pixel(331, 229, RST_MAX_DEPTH, 8'h12, 8'h34, 8'h56)); // at limit
        send_pixel(make_pixel(1024, 512, 65535, 8'hAA, 8'h55, 8'hAA)); // far above limit
        send_pixel(make_pixel(330, 230, 1000, 8'h55, 8'hAA, 8'h55));   // near center
    endtask

    // Register extremes: saturation both ways, zero reciprocals, no-result limit,
    // writes to unused indexes.
    task automatic test_register_extremes();
        drain_points();
        // Upper bits of 16-bit registers must be dropped.
        write_reg(CFG_MAX_DEPTH,   24'hFFFFFF);
        write_reg(CFG_INV_SCALE,   24'hFFFFFF);
        write_reg(CFG_CENTER_X,    24'h000000);
        write_reg(CFG_CENTER_Y,    24'hFF0000);
        write_reg(CFG_INV_FOCAL_X, 24'hFFFFFF);
        write_reg(CFG_INV_FOCAL_Y, 24'hFFFFFF);
        send_pixel(make_pixel(2047, 2047, 65534, 1, 2, 3));   // clamps positive
        send_pixel(make_pixel(0, 0, 65534, 4, 5, 6));         // on the principal point
        send_pixel(make_pixel(1, 1, 1, 7, 8, 9));

        drain_points();
        write_reg(CFG_CENTER_X, 24'h00FFFF);
        write_reg(CFG_CENTER_Y, 24'hFFFFFF);
        send_pixel(make_pixel(0, 0, 65534, 10, 11, 12));      // clamps negative
        send_pixel(make_pixel(2047, 2047, 65534, 13, 14, 15)); // small negative offset, still clamps negative
        send_pixel(make_pixel(2047, 0, 1, 16, 17, 18));

        // Zero depth scale: z and both coordinates come out zero.
        drain_points();
        write_reg(CFG_INV_SCALE, 24'h000000);
        send_pixel(make_pixel(100, 100, 300, 19, 20, 21));

        // Zero focal reciprocals: x and y zero, z normal.
        drain_points();
        write_reg(CFG_INV_SCALE,   CFG_DATA_W'(RST_INV_SCALE));
        write_reg(CFG_INV_FOCAL_X, 24'h000000);
        write_reg(CFG_INV_FOCAL_Y, 24'h000000);
        send_pixel(make_pixel(2047, 0, 4000, 22, 23, 24));

        // Zero limit: nothing gets through.
        drain_points();
        write_reg(CFG_MAX_DEPTH, 24'h000000);
        send_pixel(make_pixel(500, 500, 1, 25, 26, 27));
        send_pixel(make_pixel(500, 500, 65535, 28, 29, 30));

        // Unused indexes must leave every register alone.
        drain_points();
        write_reg(CFG_MAX_DEPTH, CFG_DATA_W'(RST_MAX_DEPTH));
        write_reg(CFG_SPARE_LO, 24'hFFFFFF);
        write_reg(CFG_SPARE_HI, 24'hFFFFFF);
        send_pixel(make_pixel(700, 300, 2500, 31, 32, 33));
    endtask

    // Receiver holds off while the sender streams usable pixels, so the block
    // fills and stalls its input. Then the sender waits for every point and streams again into a steady receiver.
    task automatic test_backpressure();
        t_pixel px;
        drain_points();
        write_reset_values();
        tx_steady   = 1'b1;
        rx_hold_req = 150;
        repeat (64) begin
            px = random_pixel();
            px.depth = DEPTH_W'($urandom_range(1, max_depth_r - 1));
            send_pixel(px);
        end
        drain_points();
        rx_steady = 1'b1;
        repeat (40) begin
            px = random_pixel();
            px.depth = DEPTH_W'($urandom_range(1, max_depth_r - 1));
            send_pixel(px);
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    // Random register settings per phase, random pixels within each phase.
    // Some phases run one side or the other without gaps.
    task automatic test_random_pixels();
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            drain_points();
            randomize_registers();
            tx_steady = (phase % 4 == 3);
            rx_steady = (phase % 5 == 4);
            repeat (PHASE_PIXELS) send_pixel(random_pixel());
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Receiver: random ready, steady ready, or a one-shot long hold-off
    // counted here in cycles.
    // ------------------------------------------------------------------
    initial begin : rx_driver
        int gap;
        forever begin
            @(negedge i_clk);
            if (rx_hold_req > 0) begin
                gap = rx_hold_req;
                rx_hold_req = 0;
                i_m_tready <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end else if (rx_steady) begin
                i_m_tready <= 1'b1;
            end else begin
                gap = pick_gap();
                i_m_tready <= (gap == 0);
                if (gap > 1)
                    repeat (gap - 1) @(negedge i_clk);
            end
        end
    end

    // ------------------------------------------------------------------
    // Point checker: each output transfer against the oldest owed point.
    // ------------------------------------------------------------------
    task automatic check_field(input string name, input logic [POS_W-1:0] want,
                               input logic [POS_W-1:0] got);
        if (got !== want) begin
            $display("%0t ns: %s expected %h, got %h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin : point_checker
        t_point want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_points.size() == 0) begin
                $display("%0t ns: point transfer with none owed, expected nothing, got %h",
                         $time, o_m_tdata);
                mismatch_count++;
            end else begin
                want = pending_points.pop_front();
                check_field("x_pos", want.x_pos, o_m_tdata[31:0]);
                check_field("y_pos", want.y_pos, o_m_tdata[63:32]);
                check_field("z_pos", want.z_pos, o_m_tdata[95:64]);
                check_field("out_blue", POS_W'(want.blue), POS_W'(o_m_tdata[103:96]));
                check_field("out_green", POS_W'(want.green), POS_W'(o_m_tdata[111:104]));
                check_field("out_red", POS_W'(want.red), POS_W'(o_m_tdata[119:112]));
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_defaults();
        test_register_extremes();
        test_backpressure();
        test_random_pixels();
        drain_points();
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Watchdog: well past the slowest legal run.
    initial begin
        #(RUN_LIMIT_NS);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
